@@ rtl/bounded_deque_with_remove_macros.svh @@
// assertion macros for the bounded deque with remove
// used by the top level only, expects clk and rst_n in scope
`ifndef BOUNDED_DEQUE_WITH_REMOVE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_MACROS_SVH

`ifndef SYNTHESIS

`define BDR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

`define BDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`else

`define BDR_ASSERT_NOW(label, ante, cons)

`define BDR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/bdr_pkg.sv @@
// types and constants shared by the bounded deque with remove
// no dependencies
`default_nettype none

package bdr_pkg;

    localparam int DATA_W  = 32;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_REMOVE     = 3'd4,
        REQ_DUMP_FWD   = 3'd5,
        REQ_DUMP_BACK  = 3'd6
    } req_code_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RM_PICK,
        S_RM_SHIFT,
        S_DUMP
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     live;
    } cell_ctl_t;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] data_value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] out_value;
        logic                     out_valid;
        logic                     last_item;
        logic [ENTRY_W-1:0]       entry_count;
    } rsp_t;

endpackage

`default_nettype wire

@@ rtl/bdr_cell.sv @@
// one storage cell of the deque ring
// depends on bdr_pkg
`default_nettype none

module bdr_cell (
    input  logic                               clk,
    input  bdr_pkg::cell_ctl_t                 ctl,
    input  logic signed [bdr_pkg::DATA_W-1:0]  left_value,
    input  logic signed [bdr_pkg::DATA_W-1:0]  right_value,
    input  logic signed [bdr_pkg::DATA_W-1:0]  load_value,
    input  logic signed [bdr_pkg::DATA_W-1:0]  key,
    output logic signed [bdr_pkg::DATA_W-1:0]  value,
    output logic                               match
);
    import bdr_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    always_comb
    begin
        unique case (ctl.op)
            CELL_HOLD:       value_next = value_reg;
            CELL_LOAD:       value_next = load_value;
            CELL_FROM_LEFT:  value_next = left_value;
            CELL_FROM_RIGHT: value_next = right_value;
            default:         value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    // only occupied cells may report a hit
    assign match = ctl.live && (value_reg == key);

endmodule

`default_nettype wire

@@ rtl/bounded_deque_with_remove.sv @@
// top level of the bounded deque with remove: ring of cells plus sequencer
// depends on bdr_pkg, bdr_cell and bounded_deque_with_remove_macros.svh
`default_nettype none

// Bounded deque of signed 32-bit entries held in a ring of CAPACITY cells, cell 0 is the
// front. One request is taken at a time; the request port stalls until the result of the
// current one has been placed in the output register, which then waits for the consumer
// while the next request is already accepted. Remove by value compares every cell at once,
// picks the entry, then shifts the tail forward one cell, or reports not found when nothing
// matches. A dump rotates the whole ring once, one step per cycle, emitting one beat per
// entry from cell 0 (forward) or cell CAPACITY-1 (backward) and marking the last; the ring
// is back in place at the end. A stalled output register holds the sequence until the
// consumer takes the beat. Empty dumps, pops and removes give one beat with status empty;
// a push to a full deque gives status full. entry_count carries the low 5 bits of the
// count. No clearing pass after reset.
module bounded_deque_with_remove #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bdr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bdr_pkg::rsp_t rsp
);
    import bdr_pkg::*;

    `include "bounded_deque_with_remove_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    state_t              state_reg, state_next;
    req_t                req_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAPACITY-1:0] match_reg;
    logic [CAPACITY-1:0] shift_reg;
    logic [IDX_W-1:0]    step_reg, step_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic signed [DATA_W-1:0] cell_val [CAPACITY];
    cell_ctl_t                cell_ctl [CAPACITY];
    logic [CAPACITY-1:0]      cell_match;
    logic [CAPACITY-1:0]      tail;

    logic [CAPACITY-1:0] load_mask;
    logic [CAPACITY-1:0] right_mask;
    logic                left_all;
    logic                match_load;
    logic                shift_load;
    logic                emit;

    logic                out_free;
    logic                full;
    logic                empty;
    logic                dump_fwd;
    logic                dump_emit;
    logic                dump_advance;
    logic                rm_done;
    logic [CAPACITY-1:0] low_hit;
    logic [CAPACITY-1:0] pick_hot;
    logic [CAPACITY-1:0] pick_mask;
    logic signed [DATA_W-1:0] tail_value;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign dump_fwd = (req_reg.req_type == REQ_DUMP_FWD);

    // forward dump emits during the first count steps, backward during the last count
    assign dump_emit    = dump_fwd ? (CNT_W'(step_reg) < count_reg)
                                   : (CNT_W'(step_reg) >= (CNT_W'(CAPACITY) - count_reg));
    assign dump_advance = !dump_emit || out_free;

    // remove order: front, then back, then lowest hit
    assign low_hit   = match_reg & (~match_reg + CAPACITY'(1));
    assign pick_hot  = match_reg[0] ? CAPACITY'(1)
                     : ((match_reg & tail) != '0) ? tail : low_hit;
    assign pick_mask = ~(pick_hot - CAPACITY'(1));

    always_comb
    begin
        tail_value = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (tail[k])
            begin
                tail_value = tail_value | cell_val[k];
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign tail[gi] = (CNT_W'(gi + 1) == count_reg);

            always_comb
            begin
                cell_ctl[gi].live = (CNT_W'(gi) < count_reg);
                if (load_mask[gi])
                begin
                    cell_ctl[gi].op = CELL_LOAD;
                end
                else if (left_all)
                begin
                    cell_ctl[gi].op = CELL_FROM_LEFT;
                end
                else if (right_mask[gi])
                begin
                    cell_ctl[gi].op = CELL_FROM_RIGHT;
                end
                else
                begin
                    cell_ctl[gi].op = CELL_HOLD;
                end
            end

            bdr_cell u_cell (
                .clk         (clk),
                .ctl         (cell_ctl[gi]),
                .left_value  (cell_val[(gi + CAPACITY - 1) % CAPACITY]),
                .right_value (cell_val[(gi + 1) % CAPACITY]),
                .load_value  (req_reg.data_value),
                .key         (req_reg.data_value),
                .value       (cell_val[gi]),
                .match       (cell_match[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (req_reg.req_type == REQ_REMOVE && !empty)
                begin
                    state_next = S_RM_PICK;
                end
                else if ((req_reg.req_type == REQ_DUMP_FWD ||
                          req_reg.req_type == REQ_DUMP_BACK) && !empty)
                begin
                    state_next = S_DUMP;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            S_RM_PICK:
            begin
                priority if (match_reg != '0)
                begin
                    state_next = S_RM_SHIFT;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = state_reg;
                end
            end
            S_RM_SHIFT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (dump_advance && step_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath control and result beat
    always_comb
    begin
        emit       = 1'b0;
        rsp_next   = '0;
        count_next = count_reg;
        load_mask  = '0;
        right_mask = '0;
        left_all   = 1'b0;
        match_load = 1'b0;
        shift_load = 1'b0;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
            end
            S_EXEC:
            begin
                unique case (req_reg.req_type)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                rsp_next.status = ST_OK;
                                count_next      = count_reg + CNT_W'(1);
                                if (req_reg.req_type == REQ_PUSH_FRONT)
                                begin
                                    left_all     = 1'b1;
                                    load_mask[0] = 1'b1;
                                end
                                else
                                begin
                                    load_mask = tail << 1;
                                    if (empty)
                                    begin
                                        load_mask[0] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            if (empty)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rsp_next.status    = ST_OK;
                                rsp_next.out_valid = 1'b1;
                                count_next         = count_reg - CNT_W'(1);
                                if (req_reg.req_type == REQ_POP_FRONT)
                                begin
                                    rsp_next.out_value = cell_val[0];
                                    right_mask         = '1;
                                end
                                else
                                begin
                                    rsp_next.out_value = tail_value;
                                end
                            end
                        end
                    end
                    REQ_REMOVE, REQ_DUMP_FWD, REQ_DUMP_BACK:
                    begin
                        if (empty)
                        begin
                            if (out_free)
                            begin
                                emit            = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                        end
                        else
                        begin
                            match_load = (req_reg.req_type == REQ_REMOVE);
                            step_next  = '0;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            emit            = 1'b1;
                            rsp_next.status = ST_OK;
                        end
                    end
                endcase
            end
            S_RM_PICK:
            begin
                if (match_reg == '0)
                begin
                    if (out_free)
                    begin
                        emit            = 1'b1;
                        rsp_next.status = ST_NOTFOUND;
                    end
                end
                else
                begin
                    shift_load = 1'b1;
                end
            end
            S_RM_SHIFT:
            begin
                if (out_free)
                begin
                    emit               = 1'b1;
                    rsp_next.status    = ST_OK;
                    rsp_next.out_valid = 1'b1;
                    rsp_next.out_value = req_reg.data_value;
                    right_mask         = shift_reg;
                    count_next         = count_reg - CNT_W'(1);
                end
            end
            S_DUMP:
            begin
                if (dump_advance)
                begin
                    step_next = step_reg + IDX_W'(1);
                    if (dump_fwd)
                    begin
                        right_mask = '1;
                    end
                    else
                    begin
                        left_all = 1'b1;
                    end
                    if (dump_emit)
                    begin
                        emit               = 1'b1;
                        rsp_next.status    = ST_OK;
                        rsp_next.out_valid = 1'b1;
                        rsp_next.out_value = dump_fwd ? cell_val[0] : cell_val[CAPACITY-1];
                    end
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
        // every beat is final except the inner beats of a dump
        if (state_reg == S_DUMP)
        begin
            rsp_next.last_item = dump_fwd ? (CNT_W'(step_reg) == count_reg - CNT_W'(1))
                                          : (step_reg == IDX_W'(CAPACITY - 1));
        end
        else
        begin
            rsp_next.last_item = 1'b1;
        end
        rsp_next.entry_count = ENTRY_W'(count_next);
    end

    assign rsp_valid_next = emit || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        if (match_load)
        begin
            match_reg <= cell_match;
        end
        if (shift_load)
        begin
            shift_reg <= pick_mask;
        end
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rm_done = (state_reg == S_RM_SHIFT) && out_free;

    `BDR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `BDR_ASSERT_NOW(a_shift_nonzero, state_reg == S_RM_SHIFT, shift_reg != '0)
    `BDR_ASSERT_NEXT(a_remove_drops_one, rm_done, count_reg == $past(count_reg) - CNT_W'(1))

endmodule

`default_nettype wire
